// ===== hw/rtl/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// sha512_pkg
// constants and helper functions for the sha-512 hash engine
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned ROUNDS   = 80;
    localparam int unsigned BLK_WORDS = 16;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word PAD_MARK = 64'h8000_0000_0000_0000;

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word v;
        case (idx)
            3'd0: v = 64'h6A09E667F3BCC908;
            3'd1: v = 64'hBB67AE8584CAA73B;
            3'd2: v = 64'h3C6EF372FE94F82B;
            3'd3: v = 64'hA54FF53A5F1D36F1;
            3'd4: v = 64'h510E527FADE682D1;
            3'd5: v = 64'h9B05688C2B3E6C1F;
            3'd6: v = 64'h1F83D9ABFB41BD6B;
            default: v = 64'h5BE0CD19137E2179;
        endcase
        return v;
    endfunction

    function automatic t_word round_k(input logic [6:0] r);
        t_word v;
        case (r)
            7'd0: v = 64'h428A2F98D728AE22;  7'd1: v = 64'h7137449123EF65CD;
            7'd2: v = 64'hB5C0FBCFEC4D3B2F;  7'd3: v = 64'hE9B5DBA58189DBBC;
            7'd4: v = 64'h3956C25BF348B538;  7'd5: v = 64'h59F111F1B605D019;
            7'd6: v = 64'h923F82A4AF194F9B;  7'd7: v = 64'hAB1C5ED5DA6D8118;
            7'd8: v = 64'hD807AA98A3030242;  7'd9: v = 64'h12835B0145706FBE;
            7'd10: v = 64'h243185BE4EE4B28C; 7'd11: v = 64'h550C7DC3D5FFB4E2;
            7'd12: v = 64'h72BE5D74F27B896F; 7'd13: v = 64'h80DEB1FE3B1696B1;
            7'd14: v = 64'h9BDC06A725C71235; 7'd15: v = 64'hC19BF174CF692694;
            7'd16: v = 64'hE49B69C19EF14AD2; 7'd17: v = 64'hEFBE4786384F25E3;
            7'd18: v = 64'h0FC19DC68B8CD5B5; 7'd19: v = 64'h240CA1CC77AC9C65;
            7'd20: v = 64'h2DE92C6F592B0275; 7'd21: v = 64'h4A7484AA6EA6E483;
            7'd22: v = 64'h5CB0A9DCBD41FBD4; 7'd23: v = 64'h76F988DA831153B5;
            7'd24: v = 64'h983E5152EE66DFAB; 7'd25: v = 64'hA831C66D2DB43210;
            7'd26: v = 64'hB00327C898FB213F; 7'd27: v = 64'hBF597FC7BEEF0EE4;
            7'd28: v = 64'hC6E00BF33DA88FC2; 7'd29: v = 64'hD5A79147930AA725;
            7'd30: v = 64'h06CA6351E003826F; 7'd31: v = 64'h142929670A0E6E70;
            7'd32: v = 64'h27B70A8546D22FFC; 7'd33: v = 64'h2E1B21385C26C926;
            7'd34: v = 64'h4D2C6DFC5AC42AED; 7'd35: v = 64'h53380D139D95B3DF;
            7'd36: v = 64'h650A73548BAF63DE; 7'd37: v = 64'h766A0ABB3C77B2A8;
            7'd38: v = 64'h81C2C92E47EDAEE6; 7'd39: v = 64'h92722C851482353B;
            7'd40: v = 64'hA2BFE8A14CF10364; 7'd41: v = 64'hA81A664BBC423001;
            7'd42: v = 64'hC24B8B70D0F89791; 7'd43: v = 64'hC76C51A30654BE30;
            7'd44: v = 64'hD192E819D6EF5218; 7'd45: v = 64'hD69906245565A910;
            7'd46: v = 64'hF40E35855771202A; 7'd47: v = 64'h106AA07032BBD1B8;
            7'd48: v = 64'h19A4C116B8D2D0C8; 7'd49: v = 64'h1E376C085141AB53;
            7'd50: v = 64'h2748774CDF8EEB99; 7'd51: v = 64'h34B0BCB5E19B48A8;
            7'd52: v = 64'h391C0CB3C5C95A63; 7'd53: v = 64'h4ED8AA4AE3418ACB;
            7'd54: v = 64'h5B9CCA4F7763E373; 7'd55: v = 64'h682E6FF3D6B2B8A3;
            7'd56: v = 64'h748F82EE5DEFB2FC; 7'd57: v = 64'h78A5636F43172F60;
            7'd58: v = 64'h84C87814A1F0AB72; 7'd59: v = 64'h8CC702081A6439EC;
            7'd60: v = 64'h90BEFFFA23631E28; 7'd61: v = 64'hA4506CEBDE82BDE9;
            7'd62: v = 64'hBEF9A3F7B2C67915; 7'd63: v = 64'hC67178F2E372532B;
            7'd64: v = 64'hCA273ECEEA26619C; 7'd65: v = 64'hD186B8C721C0C207;
            7'd66: v = 64'hEADA7DD6CDE0EB1E; 7'd67: v = 64'hF57D4F7FEE6ED178;
            7'd68: v = 64'h06F067AA72176FBA; 7'd69: v = 64'h0A637DC5A2C898A6;
            7'd70: v = 64'h113F9804BEF90DAE; 7'd71: v = 64'h1B710B35131C471B;
            7'd72: v = 64'h28DB77F523047D84; 7'd73: v = 64'h32CAAB7B40C72493;
            7'd74: v = 64'h3C9EBE0A15C9BEBC; 7'd75: v = 64'h431D67C49C100D4C;
            7'd76: v = 64'h4CC5D4BECB3E42B6; 7'd77: v = 64'h597F299CFC657E2A;
            7'd78: v = 64'h5FCB6FAB3AD6FAEC; default: v = 64'h6C44198C4A475817;
        endcase
        return v;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

// ===== hw/rtl/sha512_round.sv =====
// ----------------------------------------------------------------------------
// sha512_round
// one compression round on the working variables
// ----------------------------------------------------------------------------
module sha512_round
    import sha512_pkg::*;
(
    input  t_word       i_a, i_b, i_c, i_d, i_e, i_f, i_g, i_h,
    input  t_word       i_w,
    input  logic [6:0]  i_rnd,
    output t_word       o_a,
    output t_word       o_e
);
    t_word t1, t2;
    always_comb begin
        t1 = i_h + (rotr(i_e, 14) ^ rotr(i_e, 18) ^ rotr(i_e, 41))
             + ((i_e & i_f) ^ (~i_e & i_g)) + round_k(i_rnd) + i_w;
        t2 = (rotr(i_a, 28) ^ rotr(i_a, 34) ^ rotr(i_a, 39))
             + ((i_a & i_b) ^ (i_a & i_c) ^ (i_b & i_c));
    end
    assign o_a = t1 + t2;
    assign o_e = i_d + t1;
endmodule

// ===== hw/rtl/sha512_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha512_hash_engine
// sha-512 over a stream of big-endian 64-bit message words
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata = data_word[63:0], byte_count[67:64]; tlast = last
// m_axis    out  tdata = digest_word[63:0]; tuser = word_index[2:0]; tlast = last_word
//
// each accepted word is written to the block memory; the 16th word of a
// block starts the compression: a load of the working variables, 80 rounds
// (each of four block memory reads, a registered schedule word and the round
// update) and the chaining add. padding words go through the same memory path,
// one per cycle.
// input is stalled while compressing, padding or sending the digest.
// reset restores the initial hash and clears the byte count.
// ----------------------------------------------------------------------------
module sha512_hash_engine
    import sha512_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // data_word, byte_count, zero fill
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast
);
    typedef enum logic [3:0] {
        S_IDLE, S_PAD, S_CSTART, S_R0, S_R1, S_R2, S_R3, S_RND, S_RUP, S_FIN, S_OUT
    } t_state;

    t_state      r_state;
    t_word       r_mem [BLK_WORDS];
    t_word       r_rd;
    t_word       r_chain [8];
    t_word       r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    t_word       r_w2, r_w15, r_w7;
    t_word       r_w;
    logic [3:0]  r_wib;
    logic [127:0] r_total;
    logic [6:0]  r_rnd;
    logic [2:0]  r_oidx;
    logic        r_final;   // padding active
    logic        r_pad_len; // length words follow
    logic        r_mark;    // marker word still to be written
    logic [3:0]  r_ra;

    t_word       nx_a, nx_e, w_cur, sched;
    t_word       pad_word;
    logic        pad_write;
    logic [3:0]  nb;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_chain[r_oidx];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == 3'd7);

    assign sched = (rotr(r_w2, 19) ^ rotr(r_w2, 61) ^ (r_w2 >> 6)) + r_w7
                   + (rotr(r_w15, 1) ^ rotr(r_w15, 8) ^ (r_w15 >> 7)) + r_rd;
    assign w_cur = (r_rnd < 7'd16) ? r_rd : sched;

    sha512_round u_round (
        .i_a(r_a), .i_b(r_b), .i_c(r_c), .i_d(r_d),
        .i_e(r_e), .i_f(r_f), .i_g(r_g), .i_h(r_h),
        .i_w(r_w), .i_rnd(r_rnd), .o_a(nx_a), .o_e(nx_e)
    );

    always_comb begin
        nb = (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];
        if (r_mark)
            pad_word = PAD_MARK;
        else if (r_pad_len)
            pad_word = (r_wib == 4'd14) ? r_total[124:61] : {r_total[60:0], 3'b000};
        else
            pad_word = '0;
        pad_write = (r_state == S_PAD) && (r_mark || r_pad_len || r_wib != 4'd14);
    end

    // block memory, registered read
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_ra];
        if (r_state == S_IDLE && s_axis_tvalid) begin
            if (!s_axis_tlast || nb == 4'd8)
                r_mem[r_wib] <= s_axis_tdata[63:0];
            else
                r_mem[r_wib] <= (s_axis_tdata[63:0] & ~(64'hFFFF_FFFF_FFFF_FFFF >> {nb, 3'b000}))
                                | (PAD_MARK >> {nb, 3'b000});
        end else if (pad_write) begin
            r_mem[r_wib] <= pad_word;
        end else if (r_state == S_R3 && r_rnd >= 7'd16) begin
            r_mem[r_rnd[3:0]] <= sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wib     <= '0;
            r_total   <= '0;
            r_final   <= 1'b0;
            r_pad_len <= 1'b0;
            r_mark    <= 1'b0;
            r_oidx    <= '0;
            r_rnd     <= '0;
            r_ra      <= '0;
            for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(3'(i));
        end else begin
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    if (!s_axis_tlast) begin
                        r_total <= r_total + 128'd8;
                        r_wib   <= r_wib + 4'd1;
                        if (r_wib == 4'd15) r_state <= S_CSTART;
                    end else begin
                        r_total <= r_total + {124'd0, nb};
                        r_final <= 1'b1;
                        if (nb == 4'd8) begin
                            // marker goes in next word as padding
                            r_wib   <= r_wib + 4'd1;
                            r_state <= (r_wib == 4'd15) ? S_CSTART : S_PAD;
                            r_pad_len <= 1'b0;
                            r_mark  <= 1'b1;
                        end else begin
                            r_wib   <= r_wib + 4'd1;
                            r_pad_len <= (r_wib == 4'd13);
                            r_state <= (r_wib == 4'd15) ? S_CSTART : S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_wib <= r_wib + 4'd1;
                    r_mark <= 1'b0;
                    if (r_wib == 4'd13) r_pad_len <= 1'b1;
                    if (r_wib == 4'd15) r_state <= S_CSTART;
                end
                S_CSTART: begin
                    r_a <= r_chain[0]; r_b <= r_chain[1]; r_c <= r_chain[2];
                    r_d <= r_chain[3]; r_e <= r_chain[4]; r_f <= r_chain[5];
                    r_g <= r_chain[6]; r_h <= r_chain[7];
                    r_rnd <= '0;
                    r_ra  <= 4'd14;
                    r_state <= S_R0;
                end
                // per round: read w[r-2], w[r-15], w[r-7] and slot r mod 16 (w[r] in the first 16 rounds, else w[r-16])
                S_R0: begin r_ra <= r_rnd[3:0] + 4'd1; r_state <= S_R1; end
                S_R1: begin r_w2 <= r_rd; r_ra <= r_rnd[3:0] + 4'd9; r_state <= S_R2; end
                S_R2: begin r_w15 <= r_rd; r_ra <= r_rnd[3:0]; r_state <= S_RND; end
                S_RND: begin r_w7 <= r_rd; r_state <= S_R3; end
                S_R3: begin
                    r_w <= w_cur;
                    r_state <= S_RUP;
                end
                S_RUP: begin
                    r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= nx_e;
                    r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= nx_a;
                    r_ra <= r_rnd[3:0] + 4'd15;
                    r_rnd <= r_rnd + 7'd1;
                    r_state <= (r_rnd == 7'(ROUNDS - 1)) ? S_FIN : S_R0;
                end
                S_FIN: begin
                    r_chain[0] <= r_chain[0] + r_a; r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c; r_chain[3] <= r_chain[3] + r_d;
                    r_chain[4] <= r_chain[4] + r_e; r_chain[5] <= r_chain[5] + r_f;
                    r_chain[6] <= r_chain[6] + r_g; r_chain[7] <= r_chain[7] + r_h;
                    r_wib <= '0;
                    if (!r_final) r_state <= S_IDLE;
                    else if (r_pad_len) r_state <= S_OUT;
                    else begin
                        r_state <= S_PAD;
                        r_pad_len <= 1'b0;
                    end
                    r_oidx <= '0;
                end
                S_OUT: if (m_axis_tready) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_state <= S_IDLE;
                        r_final <= 1'b0;
                        r_pad_len <= 1'b0;
                        r_mark <= 1'b0;
                        r_total <= '0;
                        r_wib <= '0;
                        for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(3'(i));
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/sha512_checker.sv =====
// ----------------------------------------------------------------------------
// sha512_checker
// port-level checks on the sha-512 hash engine
// ----------------------------------------------------------------------------
module sha512_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input open while digest pending");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("tlast mismatch");
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("digest index skipped");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");
    a_ready_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after digest");
endmodule

bind sha512_hash_engine sha512_checker u_chk (.*);
